FILE: rtl/smpq_pkg.sv
package smpq_pkg;

   localparam int DEFAULT_CAPACITY = 8;

   localparam int KEY_W   = 32;
   localparam int REQ_W   = 2;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 4;
   localparam int RSP_DATA_W = 40;  // key, occupancy, zero fill to whole bytes

   // request kinds
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;  // latch the incoming request word
      logic execute;  // apply the request and load the result register
   } cmd_type;

endpackage

FILE: rtl/smpq_ctrl.sv
module smpq_ctrl
   import smpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_load;

   // result register is free, or its word leaves this cycle
   assign can_load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (can_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_EXEC: begin
            cmd.execute = can_load;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.execute) rsp_valid_in = 1'b1;
      else if (rsp_tready)      rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/smpq_dp.sv
module smpq_dp
   import smpq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   input  logic        [REQ_W-1:0]  req_kind,
   input  logic signed [KEY_W-1:0]  req_key,
   output logic        [STAT_W-1:0] rsp_status,
   output logic signed [KEY_W-1:0]  rsp_key,
   output logic        [OCC_W-1:0]  rsp_occ
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic        [REQ_W-1:0]  kind_ff;
   logic signed [KEY_W-1:0]  key_ff;
   logic signed [KEY_W-1:0]  cell_ff [CAPACITY];
   logic signed [KEY_W-1:0]  cell_in [CAPACITY];
   logic        [CW-1:0]     count_ff, count_in;
   logic        [STAT_W-1:0] status_ff, status_in;
   logic signed [KEY_W-1:0]  kout_ff, kout_in;
   logic        [OCC_W-1:0]  occ_ff;

   logic [CAPACITY-1:0] hit;     // held entry that the new key goes before
   logic [CAPACITY-1:0] at_pos;  // at or past the insertion point
   logic                full, empty, do_insert, do_remove;

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);
   assign do_insert = (kind_ff == REQ_INSERT) && !full;
   assign do_remove = (kind_ff == REQ_REMOVE) && !empty;

   // one compare per cell; the row is sorted so hit is a run up to the top
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign hit[i]    = (CW'(i) < count_ff) && (key_ff <= cell_ff[i]);
      assign at_pos[i] = hit[i] || (CW'(i) == count_ff);

      if (i == 0) begin : g_head
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (do_insert && at_pos[i]) cell_in[i] = key_ff;
            else if (do_remove)         cell_in[i] = cell_ff[i+1];
         end
      end else if (i == CAPACITY - 1) begin : g_tail
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (do_insert) begin
               if (at_pos[i-1])  cell_in[i] = cell_ff[i-1];
               else if (at_pos[i]) cell_in[i] = key_ff;
            end
         end
      end else begin : g_mid
         always_comb begin
            cell_in[i] = cell_ff[i];
            if (do_insert) begin
               if (at_pos[i-1])  cell_in[i] = cell_ff[i-1];
               else if (at_pos[i]) cell_in[i] = key_ff;
            end else if (do_remove) begin
               cell_in[i] = cell_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      status_in = STAT_OK;
      kout_in   = '0;
      count_in  = count_ff;
      unique case (kind_ff)
         REQ_INSERT: begin
            if (full) status_in = STAT_OVERFLOW;
            else      count_in  = count_ff + CW'(1);
         end
         REQ_REMOVE: begin
            if (empty) status_in = STAT_UNDERFLOW;
            else begin
               kout_in  = cell_ff[0];
               count_in = count_ff - CW'(1);
            end
         end
         REQ_READ: begin
            if (empty) status_in = STAT_UNDERFLOW;
            else       kout_in   = cell_ff[0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.execute) count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         key_ff  <= req_key;
      end
      if (cmd.execute) begin
         cell_ff   <= cell_in;
         status_ff <= status_in;
         kout_ff   <= kout_in;
         occ_ff    <= OCC_W'(count_in);
      end
   end

   assign rsp_status = status_ff;
   assign rsp_key    = kout_ff;
   assign rsp_occ    = occ_ff;

endmodule

FILE: rtl/sorted_min_priority_queue_unit.sv
// Bounded min-priority queue of signed 32-bit keys, held as an ascending row of
// CAPACITY registers. Each request word (insert, remove smallest, read smallest)
// returns one result word with a status, the smallest key for remove/read and the
// occupancy after the request (low 4 bits of the count). A request is latched in
// ST_IDLE; in ST_EXEC every cell then compares against the key and shifts in
// parallel, and the result register is loaded. The input then opens again, so a
// new request is taken only once the last one has executed. A result that is not
// taken holds the next request in its execute cycle. No clearing pass:
// the queue is ready right after reset.
module sorted_min_priority_queue_unit
   import smpq_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [KEY_W-1:0]      req_tdata,   // [31:0] key_in
   input  logic [REQ_W-1:0]      req_tuser,   // [1:0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] key_out, [35:32] occupancy
   output logic [STAT_W-1:0]     rsp_tuser    // [1:0] status
);

   cmd_type                  cmd;
   logic signed [KEY_W-1:0]  key_out;
   logic        [OCC_W-1:0]  occupancy;

   smpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   smpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_kind   (req_tuser),
      .req_key    (req_tdata),
      .rsp_status (rsp_tuser),
      .rsp_key    (key_out),
      .rsp_occ    (occupancy)
   );

   assign rsp_tdata = {(RSP_DATA_W - KEY_W - OCC_W)'(0), occupancy, key_out};

   // one request in flight: after a word is taken the input closes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in flight");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STAT_UNDERFLOW) |->
         (rsp_tdata[KEY_W-1:0] == '0 && rsp_tdata[KEY_W+OCC_W-1:KEY_W] == '0))
      else $error("underflow with nonzero key or occupancy");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STAT_OVERFLOW) |->
         (rsp_tdata[KEY_W+OCC_W-1:KEY_W] == OCC_W'(CAPACITY) &&
          rsp_tdata[KEY_W-1:0] == '0))
      else $error("overflow reported while not full");

endmodule

FILE: sim/sorted_min_priority_queue_unit_tb.sv
`timescale 1ns / 1ps

module sorted_min_priority_queue_unit_tb;
   import smpq_pkg::*;

   localparam int CAPACITY    = DEFAULT_CAPACITY;
   localparam int RANDOM_REQS = 415;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 20;
   localparam int SHOW_ERRORS = 10;

   // request code with no operation behind it
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIX
   } traffic_mode_type;

   typedef struct packed {
      logic [REQ_W-1:0] kind;
      logic [KEY_W-1:0] key;
   } pq_request_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [KEY_W-1:0]  key;
      logic [OCC_W-1:0]  occ;
   } pq_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [KEY_W-1:0]      req_tdata  = '0;   // [31:0] key_in
   logic [REQ_W-1:0]      req_tuser  = '0;   // [1:0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [31:0] key_out, [35:32] occupancy
   logic [STAT_W-1:0]     rsp_tuser;         // [1:0] status

   pq_request_type pending_reqs[$];
   pq_result_type  expected_results[$];

   // shadow of the queue contents
   logic [KEY_W-1:0] model_keys[CAPACITY];
   int               model_count = 0;

   int err_count   = 0;
   int cycle_count = 0;
   int send_gap    = 0;
   int stall_left  = 0;

   sorted_min_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // small values give plenty of equal keys
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return KEY_W'($signed($urandom_range(0, 6)) - 3);
      if (r < 40) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0001;
            default: return 32'h7fff_fffe;
         endcase
      end
      return $urandom();
   endfunction

   task automatic queue_req(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key);
      pending_reqs.push_back('{kind: kind, key: key});
   endtask

   // apply one request to the shadow queue and record the word it must return
   task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key);
      pq_result_type res;
      int            pos;
      res = '{status: STAT_OK, key: '0, occ: '0};
      if (kind == REQ_INSERT) begin
         if (model_count >= CAPACITY) begin
            res.status = STAT_OVERFLOW;
         end else begin
            pos = model_count;
            for (int i = model_count - 1; i >= 0; i--)
               if ($signed(key) <= $signed(model_keys[i])) pos = i;
            for (int i = model_count; i > pos; i--)
               model_keys[i] = model_keys[i-1];
            model_keys[pos] = key;
            model_count++;
         end
      end else if (kind == REQ_REMOVE || kind == REQ_READ) begin
         if (model_count == 0) begin
            res.status = STAT_UNDERFLOW;
         end else begin
            res.key = model_keys[0];
            if (kind == REQ_REMOVE) begin
               for (int i = 0; i + 1 < model_count; i++)
                  model_keys[i] = model_keys[i+1];
               model_count--;
            end
         end
      end
      res.occ = OCC_W'(model_count);
      expected_results.push_back(res);
   endtask

   task automatic note_mismatch(input string field, input logic [KEY_W-1:0] want,
                                input logic [KEY_W-1:0] got);
      err_count++;
      if (err_count <= SHOW_ERRORS)
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) apply_request(req_tuser, req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_reqs[0].kind;
               req_tdata  <= pending_reqs[0].key;
               void'(pending_reqs.pop_front());
               send_gap   <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor_blk
      pq_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               note_mismatch("unexpected word", '0, rsp_tdata[KEY_W-1:0]);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.status)
                  note_mismatch("status", KEY_W'(want.status), KEY_W'(rsp_tuser));
               if (rsp_tdata[KEY_W-1:0] !== want.key)
                  note_mismatch("key_out", want.key, rsp_tdata[KEY_W-1:0]);
               if (rsp_tdata[KEY_W+OCC_W-1:KEY_W] !== want.occ)
                  note_mismatch("occupancy", KEY_W'(want.occ),
                                KEY_W'(rsp_tdata[KEY_W+OCC_W-1:KEY_W]));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus_blk
      traffic_mode_type mode;
      int               mode_left;
      int               real_reqs;
      int               r;
      logic [REQ_W-1:0] kind;

      // empty queue: underflow on both reads, unused code does nothing
      queue_req(REQ_READ, 32'h1234_5678);
      queue_req(REQ_REMOVE, 32'hffff_ffff);
      queue_req(REQ_UNUSED, 32'h5a5a_a5a5);
      // fill with extremes and duplicates, including the largest key twice
      queue_req(REQ_INSERT, 32'h0000_0000);
      queue_req(REQ_INSERT, 32'h7fff_ffff);
      queue_req(REQ_INSERT, 32'h8000_0000);
      queue_req(REQ_INSERT, 32'hffff_ffff);
      queue_req(REQ_INSERT, 32'h0000_0001);
      queue_req(REQ_INSERT, 32'h0000_0000);
      queue_req(REQ_INSERT, 32'h0000_0005);
      queue_req(REQ_INSERT, 32'h7fff_ffff);
      // full
      queue_req(REQ_INSERT, 32'h0000_002a);
      queue_req(REQ_UNUSED, 32'h0000_0000);
      queue_req(REQ_READ, 32'h0000_0000);
      repeat (CAPACITY) queue_req(REQ_REMOVE, 32'h0000_0000);
      queue_req(REQ_REMOVE, 32'h0000_0000);
      queue_req(REQ_READ, 32'h0000_0000);

      mode      = MODE_MIX;
      mode_left = 0;
      real_reqs = 0;
      while (real_reqs < RANDOM_REQS) begin
         if (mode_left == 0) begin
            mode      = traffic_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(15, 40);
         end
         mode_left--;
         r = $urandom_range(0, 99);
         if (r < 3)
            kind = REQ_UNUSED;
         else if (mode == MODE_FILL)
            kind = (r < 78) ? REQ_INSERT : (r < 92) ? REQ_REMOVE : REQ_READ;
         else if (mode == MODE_DRAIN)
            kind = (r < 30) ? REQ_INSERT : (r < 80) ? REQ_REMOVE : REQ_READ;
         else
            kind = (r < 45) ? REQ_INSERT : (r < 80) ? REQ_REMOVE : REQ_READ;
         queue_req(kind, pick_key());
         if (kind != REQ_UNUSED) real_reqs++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (expected_results.size() != 0)
         note_mismatch("missing word", KEY_W'(expected_results.size()), '0);
      if (err_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
rtl/smpq_pkg.sv
rtl/smpq_ctrl.sv
rtl/smpq_dp.sv
rtl/sorted_min_priority_queue_unit.sv
sim/sorted_min_priority_queue_unit_tb.sv
